/* rtl/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion shorthands. They expand to nothing in synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/tpd_pkg.sv */
// ============================================================================
// tpd_pkg
// Types and constants shared by the text packet deframer modules.
// ============================================================================
package tpd_pkg;

    // Default payload buffer depth
    localparam int BUFFER_DEPTH_DEF = 128;

    // Output queue depth and count width
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Reset values of the delimiter registers
    localparam logic [7:0] HEADER_CHAR_RST = 8'h40;   // '@'
    localparam logic [7:0] TAIL1_CHAR_RST  = 8'h0D;   // CR
    localparam logic [7:0] TAIL2_CHAR_RST  = 8'h0A;   // LF

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER = 2'd0;
    localparam logic [1:0] CFG_TAIL1  = 2'd1;
    localparam logic [1:0] CFG_TAIL2  = 2'd2;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_RX      = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    // Receive phase
    typedef enum logic [1:0] {
        PH_WAIT_HDR   = 2'd0,
        PH_COLLECT    = 2'd1,
        PH_WAIT_TAIL2 = 2'd2
    } phase_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_HEADER = 3'd1,
        EV_STORED = 3'd2,
        EV_FULL   = 3'd3,
        EV_TAIL1  = 3'd4,
        EV_DONE   = 3'd5,
        EV_READ   = 3'd6
    } event_t;

    // Result of one step, before the payload byte is fetched
    typedef struct packed {
        event_t     ev;
        logic       ready;
        logic [7:0] length;
        phase_t     phase;
        logic       rd_ok;
    } step_res_t;

    // Complete result beat
    typedef struct packed {
        event_t     ev;
        logic       ready;
        logic [7:0] length;
        logic [7:0] rdata;
        phase_t     phase;
    } out_t;

endpackage

/* rtl/text_packet_deframer.sv */
// ============================================================================
// text_packet_deframer
// Frames header / payload / tail1 / tail2 text packets from a byte stream.
// ============================================================================
// Takes one beat per clock while s_tready is high and gives one result beat
// per input beat, in order. A beat passes the framing state machine and the
// payload memory port in the cycle it is accepted. The step result is then
// registered in stage 1 and any byte read in the memory's read register;
// both are then written into a four-entry output queue, whose head is
// presented on the output. s_tready depends only on registers: it drops
// only while four results are in flight, so with m_tready held high the
// block sustains one beat per cycle. The payload memory needs no clearing
// after reset; reads beyond the current packet length return zero.
`include "assert_macros.svh"

module text_packet_deframer #(
    parameter int BUFFER_DEPTH = tpd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] rx_byte, [14:8] read_index
    input  logic [1:0]  s_tuser,    // [1:0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [0] packet_ready, [8:1] packet_length,
                                    // [16:9] read_data, [18:17] receive_phase
    output logic [2:0]  m_tuser,    // [2:0] event_res
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic                           accept;
    tpd_pkg::op_t                   op;
    tpd_pkg::step_res_t             res;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [7:0]                     wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [7:0]                     ram_rdata;
    logic                           s1_valid_reg;
    tpd_pkg::step_res_t             s1_res_reg;
    tpd_pkg::out_t                  q_in;
    tpd_pkg::out_t                  q_head;
    logic                           q_not_empty;
    logic [tpd_pkg::OUTQ_CW-1:0]    q_count;
    logic [tpd_pkg::OUTQ_CW-1:0]    in_flight;

    assign op        = tpd_pkg::op_t'(s_tuser);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Results in flight bound the queue fill
    assign in_flight = q_count + tpd_pkg::OUTQ_CW'(s1_valid_reg);
    assign s_tready  = (in_flight < tpd_pkg::OUTQ_CW'(tpd_pkg::OUTQ_DEPTH));

    tpd_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .op         (op),
        .rx_byte    (s_tdata[7:0]),
        .read_index (s_tdata[14:8]),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    tpd_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Stage 1: hold the step result while the memory read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
    end

    // Merge read data into the result beat
    assign q_in.ev     = s1_res_reg.ev;
    assign q_in.ready  = s1_res_reg.ready;
    assign q_in.length = s1_res_reg.length;
    assign q_in.rdata  = s1_res_reg.rd_ok ? ram_rdata : 8'h00;
    assign q_in.phase  = s1_res_reg.phase;

    tpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (q_in),
        .pop       (m_tvalid && m_tready),
        .head      (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    // Output beat
    assign m_tvalid = q_not_empty;
    assign m_tuser  = q_head.ev;
    assign m_tdata  = {5'b0, q_head.phase, q_head.rdata, q_head.length, q_head.ready};

    // Checks
    `ASSERT_ALWAYS(a_queue_room, clk, rst_n,
        in_flight <= tpd_pkg::OUTQ_CW'(tpd_pkg::OUTQ_DEPTH),
        "result queue overrun")
    `ASSERT_IMPLY(a_ready_idle, clk, rst_n,
        s1_valid_reg && s1_res_reg.ready,
        s1_res_reg.phase == tpd_pkg::PH_WAIT_HDR,
        "packet ready outside header wait")
    `ASSERT_NEXT(a_read_stage, clk, rst_n,
        accept && op == tpd_pkg::OP_READ,
        s1_valid_reg && s1_res_reg.ev == tpd_pkg::EV_READ,
        "read beat lost in stage 1")

endmodule

/* rtl/tpd_store.sv */
// ============================================================================
// tpd_store
// Payload byte memory: one write port, one read port, registered read data.
// ============================================================================
module tpd_store #(
    parameter int DEPTH = tpd_pkg::BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered; holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tpd_ctrl.sv */
// ============================================================================
// tpd_ctrl
// Framing state machine, byte count, ready flag and delimiter registers.
// Issues the payload memory write for each stored byte and the read for each read beat.
// ============================================================================
module tpd_ctrl #(
    parameter int DEPTH = tpd_pkg::BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration writes
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    // accepted input beat
    input  logic                accept,
    input  tpd_pkg::op_t        op,
    input  logic [7:0]          rx_byte,
    input  logic [6:0]          read_index,
    // step result
    output tpd_pkg::step_res_t  res,
    // payload memory access
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr
);

    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [7:0]       header_reg;
    logic [7:0]       tail1_reg;
    logic [7:0]       tail2_reg;
    tpd_pkg::phase_t  phase_reg;
    tpd_pkg::phase_t  phase_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             ready_reg;
    logic             ready_next;
    tpd_pkg::event_t  ev;
    logic             is_rx;
    logic             is_full;
    logic             in_range;

    assign is_rx    = accept && (op == tpd_pkg::OP_RX);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign in_range = (CMPW'(read_index) < CMPW'(count_reg));

    // Delimiter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= tpd_pkg::HEADER_CHAR_RST;
            tail1_reg  <= tpd_pkg::TAIL1_CHAR_RST;
            tail2_reg  <= tpd_pkg::TAIL2_CHAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpd_pkg::CFG_HEADER: header_reg <= cfg_data;
                tpd_pkg::CFG_TAIL1:  tail1_reg  <= cfg_data;
                tpd_pkg::CFG_TAIL2:  tail2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_rx)
        begin
            unique case (phase_reg)
                tpd_pkg::PH_COLLECT:
                begin
                    if (rx_byte == tail1_reg)
                    begin
                        phase_next = tpd_pkg::PH_WAIT_TAIL2;
                    end
                end
                tpd_pkg::PH_WAIT_TAIL2:
                begin
                    if (rx_byte == tail2_reg)
                    begin
                        phase_next = tpd_pkg::PH_WAIT_HDR;
                    end
                end
                default:
                begin
                    if (rx_byte == header_reg && !ready_reg)
                    begin
                        phase_next = tpd_pkg::PH_COLLECT;
                    end
                end
            endcase
        end
    end

    // Event, count, ready flag and memory requests
    always_comb
    begin
        ev         = tpd_pkg::EV_NONE;
        count_next = count_reg;
        ready_next = ready_reg;
        wr_en      = 1'b0;
        if (accept)
        begin
            unique case (op)
                tpd_pkg::OP_RX:
                begin
                    unique case (phase_reg)
                        tpd_pkg::PH_COLLECT:
                        begin
                            if (rx_byte == tail1_reg)
                            begin
                                ev = tpd_pkg::EV_TAIL1;
                            end
                            else if (!is_full)
                            begin
                                ev         = tpd_pkg::EV_STORED;
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                ev = tpd_pkg::EV_FULL;
                            end
                        end
                        tpd_pkg::PH_WAIT_TAIL2:
                        begin
                            if (rx_byte == tail2_reg)
                            begin
                                ev         = tpd_pkg::EV_DONE;
                                ready_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (rx_byte == header_reg && !ready_reg)
                            begin
                                ev         = tpd_pkg::EV_HEADER;
                                count_next = '0;
                            end
                        end
                    endcase
                end
                tpd_pkg::OP_READ:
                begin
                    ev = tpd_pkg::EV_READ;
                end
                tpd_pkg::OP_RELEASE:
                begin
                    ready_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tpd_pkg::PH_WAIT_HDR;
            count_reg <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    // Memory ports: write at the fill position, read at the requested index
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = rx_byte;
    assign rd_en   = accept && (op == tpd_pkg::OP_READ);
    assign rd_addr = AW'(read_index);

    // Step result
    assign res.ev     = ev;
    assign res.ready  = ready_next;
    assign res.length = 8'(count_next);
    assign res.phase  = phase_next;
    assign res.rd_ok  = rd_en && in_range;

endmodule

/* rtl/tpd_outq.sv */
// ============================================================================
// tpd_outq
// Small result queue that decouples the input side from output stalls.
// ============================================================================
module tpd_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  tpd_pkg::out_t                 push_data,
    input  logic                          pop,
    output tpd_pkg::out_t                 head,
    output logic                          not_empty,
    output logic [tpd_pkg::OUTQ_CW-1:0]   count
);

    tpd_pkg::out_t                  entry_reg [tpd_pkg::OUTQ_DEPTH];
    logic [tpd_pkg::OUTQ_PW-1:0]    wr_ptr_reg;
    logic [tpd_pkg::OUTQ_PW-1:0]    rd_ptr_reg;
    logic [tpd_pkg::OUTQ_CW-1:0]    count_reg;
    logic [tpd_pkg::OUTQ_CW-1:0]    count_next;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tpd_pkg::OUTQ_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tpd_pkg::OUTQ_CW'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tpd_pkg::OUTQ_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tpd_pkg::OUTQ_PW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule
